/* design/gcd_lcm_unit_top_defines.svh */
// Assertion macros for the gcd/lcm unit checker.
// Needs a clk and rst signal in the scope where a macro is used.
`ifndef GCD_LCM_UNIT_TOP_DEFINES_SVH
`define GCD_LCM_UNIT_TOP_DEFINES_SVH
// Same-cycle implication.
`define GLU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcd_lcm_unit assertion failed");
// Next-cycle implication.
`define GLU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcd_lcm_unit assertion failed");
`endif

/* design/glu_pkg.sv */
// Package for the gcd/lcm unit: sequencer states and widths.
// No dependencies.
package glu_pkg;
  localparam int unsigned DW = 64;
  localparam int unsigned CW = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EUC,
    ST_DIV,
    ST_LCM,
    ST_DONE
  } state_t;
endpackage

/* design/gcd_lcm_unit_top.sv */
// GCD and LCM of two signed 64-bit magnitudes, one shared 66-bit adder.
// After acceptance: shift-add multiply, one restoring divide per Euclid remainder
// step, the final divide (dropped when both operands are zero), then done.
// No new transaction until done; start is taken only while busy is low.
// Result shows for one cycle with done high; the receiver cannot stall.
// Reset (rst, synchronous, active high) returns the sequencer to idle.
// Depends on glu_pkg.
module gcd_lcm_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_a,
  input  logic [63:0] value_b,
  output logic        done,
  output logic [63:0] gcd_result,
  output logic [63:0] lcm_result,
  output logic        lcm_wrapped,
  output logic        zero_divide
);

  glu_pkg::state_t state, state_next;

  logic [63:0] ma;        // magnitude of value_a, multiplicand
  logic [63:0] prod_hi;   // upper half of product
  logic [63:0] prod_lo;   // multiplier shifting out, product low half shifting in
  logic [63:0] x;         // dividend, shifts into quotient
  logic [63:0] y;         // divisor
  logic [63:0] r;         // partial remainder
  logic [glu_pkg::CW-1:0] cnt;
  logic        lcm_phase; // current divide is the final lcm divide
  logic [63:0] g;
  logic [63:0] lcm;
  logic        wrapped;
  logic        zdiv;

  // Shared adder: add during multiply, subtract during divide.
  logic [65:0] alu_a, alu_b, alu_sum;
  logic        alu_sub;
  logic        last;

  assign last = (cnt == {glu_pkg::CW{1'b1}});

  always_comb begin
    alu_sub = (state == glu_pkg::ST_DIV);
    if (alu_sub) begin
      alu_a = {1'b0, r, x[63]};
      alu_b = {2'b00, y};
    end else begin
      alu_a = {2'b00, prod_hi};
      alu_b = {2'b00, ma};
    end
    alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {65'd0, alu_sub};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      glu_pkg::ST_IDLE: if (start) state_next = glu_pkg::ST_MUL;
      glu_pkg::ST_MUL:  if (last) state_next = glu_pkg::ST_EUC;
      glu_pkg::ST_EUC:  if (y == 64'd0) state_next = glu_pkg::ST_LCM;
                        else state_next = glu_pkg::ST_DIV;
      glu_pkg::ST_DIV: begin
        if (last) state_next = lcm_phase ? glu_pkg::ST_DONE : glu_pkg::ST_EUC;
      end
      glu_pkg::ST_LCM: begin
        if (x == 64'd0) state_next = glu_pkg::ST_DONE;
        else state_next = glu_pkg::ST_DIV;
      end
      glu_pkg::ST_DONE: state_next = glu_pkg::ST_IDLE;
      default:          state_next = glu_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy        = (state != glu_pkg::ST_IDLE);
    done        = (state == glu_pkg::ST_DONE);
    gcd_result  = g;
    lcm_result  = lcm;
    lcm_wrapped = wrapped;
    zero_divide = zdiv;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= glu_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      glu_pkg::ST_IDLE: begin
        // Take magnitudes; -2^63 maps to 2^63 unsigned.
        ma      <= value_a[63] ? (64'd0 - value_a) : value_a;
        prod_lo <= value_b[63] ? (64'd0 - value_b) : value_b;
        x       <= value_a[63] ? (64'd0 - value_a) : value_a;
        y       <= value_b[63] ? (64'd0 - value_b) : value_b;
        prod_hi <= 64'd0;
        cnt     <= '0;
        lcm_phase <= 1'b0;
      end
      glu_pkg::ST_MUL: begin
        // Shift-add one multiplier bit per cycle.
        if (prod_lo[0]) {prod_hi, prod_lo} <= {alu_sum[64:0], prod_lo[63:1]};
        else            {prod_hi, prod_lo} <= {1'b0, prod_hi, prod_lo[63:1]};
        cnt <= cnt + 1'b1;
      end
      glu_pkg::ST_EUC: begin
        // Divisor zero ends Euclid; otherwise start the remainder step.
        r   <= 64'd0;
        cnt <= '0;
        if (y == 64'd0) g <= x;
        wrapped <= (prod_hi != 64'd0);
      end
      glu_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        cnt <= cnt + 1'b1;
        if (last && !lcm_phase) begin
          // Advance Euclid: divisor becomes dividend, remainder the divisor.
          x <= y;
          y <= alu_sum[65] ? {r[62:0], x[63]} : alu_sum[63:0];
        end else begin
          if (!alu_sum[65]) begin
            r <= alu_sum[63:0];
            x <= {x[62:0], 1'b1};
          end else begin
            r <= {r[62:0], x[63]};
            x <= {x[62:0], 1'b0};
          end
          if (last) lcm <= {x[62:0], ~alu_sum[65]};
        end
      end
      glu_pkg::ST_LCM: begin
        // Set up wrapped product / gcd; both operands zero gives zero_divide.
        zdiv      <= (x == 64'd0);
        lcm       <= 64'd0;
        lcm_phase <= 1'b1;
        y         <= x;
        x         <= prod_lo;
        r         <= 64'd0;
        cnt       <= '0;
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/glu_checker.sv */
// Port-level checker for the gcd/lcm unit, bound to the top level.
// Depends on gcd_lcm_unit_top_defines.svh.
`include "gcd_lcm_unit_top_defines.svh"
module glu_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [63:0] gcd_result,
  input logic [63:0] lcm_result,
  input logic        zero_divide
);
  `GLU_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `GLU_ASSERT_NOW(a_done_busy, done, busy)
  `GLU_ASSERT_NEXT(a_done_once, done, !done && !busy)
  `GLU_ASSERT_NOW(a_zdiv_zero, done && zero_divide, gcd_result == 64'd0 && lcm_result == 64'd0)
endmodule

bind gcd_lcm_unit_top glu_checker u_glu_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .gcd_result(gcd_result), .lcm_result(lcm_result), .zero_divide(zero_divide)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gcd_lcm_unit_top: directed corner operands, then
// random bursts of transactions checked against an in-bench GCD/LCM predictor.
// Depends on the gcd_lcm_unit_top RTL only.

// Holds the expected results of accepted transactions, in order of acceptance.
class gcd_lcm_scoreboard;
  typedef struct packed {
    logic [63:0] gcd;
    logic [63:0] lcm;
    logic        wrapped;
    logic        zdiv;
  } gcd_lcm_t;

  gcd_lcm_t    pending_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned wrapped_seen;
  int unsigned zdiv_seen;

  function new();
    mismatches   = 0;
    results_seen = 0;
    wrapped_seen = 0;
    zdiv_seen    = 0;
  endfunction

  static function logic [63:0] abs64(logic [63:0] raw);
    return raw[63] ? (64'd0 - raw) : raw;
  endfunction

  // Euclid on magnitudes; the product is kept at 128 bits to spot the wrap.
  function gcd_lcm_t predict_gcd_lcm(logic [63:0] a, logic [63:0] b);
    gcd_lcm_t     exp_r;
    logic [63:0]  x;
    logic [63:0]  y;
    logic [63:0]  r;
    logic [127:0] full_prod;
    x         = abs64(a);
    y         = abs64(b);
    full_prod = {64'd0, x} * {64'd0, y};
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    exp_r.gcd     = x;
    exp_r.wrapped = (full_prod[127:64] != 64'd0);
    exp_r.zdiv    = (x == 64'd0);
    exp_r.lcm     = exp_r.zdiv ? 64'd0 : full_prod[63:0] / x;
    return exp_r;
  endfunction

  function void note_operands(logic [63:0] a, logic [63:0] b);
    pending_q.push_back(predict_gcd_lcm(a, b));
  endfunction

  function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
  endfunction

  function void check_result(logic [63:0] g, logic [63:0] l, logic w, logic z);
    gcd_lcm_t exp_r;
    results_seen++;
    if (w) wrapped_seen++;
    if (z) zdiv_seen++;
    if (pending_q.size() == 0) begin
      report("unexpected result (gcd)", 64'd0, g);
      return;
    end
    exp_r = pending_q.pop_front();
    if (g !== exp_r.gcd)     report("gcd_result", exp_r.gcd, g);
    if (l !== exp_r.lcm)     report("lcm_result", exp_r.lcm, l);
    if (w !== exp_r.wrapped) report("lcm_wrapped", {63'd0, exp_r.wrapped}, {63'd0, w});
    if (z !== exp_r.zdiv)    report("zero_divide", {63'd0, exp_r.zdiv}, {63'd0, z});
  endfunction

  function int unsigned outstanding();
    return pending_q.size();
  endfunction
endclass

module tb;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
  localparam int unsigned RANDOM_ITEMS = 400;
  // Worst case is a long Euclid chain plus the multiply and the final divide;
  // allow every transaction that and a sender gap, then multiply by three.
  localparam longint unsigned CYCLE_LIMIT = 64'd3 * (RANDOM_ITEMS + 30) * 6500;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] value_a;
  logic [63:0] value_b;
  logic        done;
  logic [63:0] gcd_result;
  logic [63:0] lcm_result;
  logic        lcm_wrapped;
  logic        zero_divide;

  gcd_lcm_scoreboard gcd_lcm_sb;
  longint unsigned   cycle_count;
  int unsigned       txns_sent;

  gcd_lcm_unit_top DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value_a     (value_a),
    .value_b     (value_b),
    .done        (done),
    .gcd_result  (gcd_result),
    .lcm_result  (lcm_result),
    .lcm_wrapped (lcm_wrapped),
    .zero_divide (zero_divide)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Check every strobed result; the receiver cannot stall, so sample each
  // done cycle at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done)
      gcd_lcm_sb.check_result(gcd_result, lcm_result, lcm_wrapped, zero_divide);
  end

  // Watchdog: drop the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** gcd_lcm_unit_top: FAILED **");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. Start is
  // left high, so a back-to-back transaction simply overwrites the operands.
  task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
    start   <= 1'b1;
    value_a <= a;
    value_b <= b;
    do @(posedge clk); while (busy);
    gcd_lcm_sb.note_operands(a, b);
    txns_sent++;
  endtask

  // Drop start and idle the sender for a number of cycles.
  task automatic sender_gap(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and hold off until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (gcd_lcm_sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random signed operand: full width, a narrow magnitude or a corner value.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int unsigned bits;
    case ($urandom_range(9))
      0, 1, 2: v = rand64();
      3: begin
        case ($urandom_range(5))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = '1;
          3: v = MOST_NEG;
          4: v = MOST_POS;
          default: v = 64'd1 << $urandom_range(63);
        endcase
      end
      default: begin
        bits = $urandom_range(64, 1);
        v    = rand64() & ({64{1'b1}} >> (64 - bits));
        if ($urandom_range(1)) v = 64'd0 - v;
      end
    endcase
    return v;
  endfunction

  // Pair with a shared factor, so the GCD is non-trivial.
  task automatic send_related_pair();
    logic [63:0] factor;
    logic [63:0] a;
    logic [63:0] b;
    factor = rand64() >> $urandom_range(63, 20);
    a      = factor * ($urandom >> $urandom_range(31));
    b      = factor * ($urandom >> $urandom_range(31));
    if ($urandom_range(1)) a = 64'd0 - a;
    if ($urandom_range(1)) b = 64'd0 - b;
    send_pair(a, b);
  endtask

  initial begin
    int unsigned burst;
    int unsigned n;
    gcd_lcm_sb  = new();
    cycle_count = 0;
    txns_sent   = 0;
    rst         = 1'b1;
    start       = 1'b0;
    value_a     = 64'd0;
    value_b     = 64'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: zeros, most negative, wraps, long Euclid chain.
    send_pair(64'd0, 64'd0);
    send_pair(64'd5, 64'd0);
    send_pair(64'd0, -64'sd7);
    send_pair(MOST_NEG, 64'd0);
    send_pair(64'd0, MOST_NEG);
    send_pair(MOST_NEG, MOST_NEG);
    send_pair(MOST_POS, MOST_POS);
    send_pair(MOST_NEG, MOST_POS);
    send_pair('1, '1);
    send_pair(64'd1, MOST_NEG);
    send_pair(MOST_POS, 64'd1);
    send_pair(64'd12, 64'd18);
    send_pair(-64'sd12, 64'd18);
    send_pair(64'd18, -64'sd12);
    send_pair(64'h1_0000_0000, 64'h1_0000_0000);
    send_pair(MOST_NEG, 64'd2);
    send_pair(64'd7540113804746346429, 64'd4660046610375530309);
    send_pair(64'hffff_ffff_ffff_fffe, 64'd3);
    send_pair(64'hffff_ffff, 64'h1_0000_0001);
    drain_results();

    // Random bursts with random gaps; one full drain half way through.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(12, 1);
      repeat (burst) begin
        if ($urandom_range(3) == 0) send_related_pair();
        else send_pair(rand_operand(), rand_operand());
        n++;
      end
      if (n >= RANDOM_ITEMS / 2 && n - burst < RANDOM_ITEMS / 2)
        drain_results();
      else if ($urandom_range(2) != 0)
        sender_gap($urandom_range(150, 1));
    end
    start <= 1'b0;

    // Wait for the last results, then a little longer for strays.
    while (gcd_lcm_sb.outstanding() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("sent %0d transactions, checked %0d results (%0d wrapped, %0d zero-divide)",
             txns_sent, gcd_lcm_sb.results_seen, gcd_lcm_sb.wrapped_seen,
             gcd_lcm_sb.zdiv_seen);
    $display("mismatches: %0d", gcd_lcm_sb.mismatches);
    if (gcd_lcm_sb.mismatches == 0 && gcd_lcm_sb.outstanding() == 0)
      $display("** gcd_lcm_unit_top: PASSED **");
    else
      $display("** gcd_lcm_unit_top: FAILED **");
    $finish;
  end
endmodule
